>>> src/kste_pkg.sv
// ----------------------------------------------------------------------------
// kste_pkg: shared types and constants for the key scan event encoder
// Field widths, transaction codes, FSM states and the key code table.
// ----------------------------------------------------------------------------
package kste_pkg;

  localparam int SCAN_W    = 53;  // scan bitmap width
  localparam int ROM_ROWS  = 53;  // rows in the key code table
  localparam int ROW_W     = 6;   // table row index width
  localparam int POWER_BIT = 7;
  localparam int LAYER0_KEY = 14;
  localparam int LAYER1_KEY = 15;
  localparam int ARROW_W   = 4;   // arrow keys are bits 0..3
  localparam int CODE_W    = 10;
  localparam int VAL_W     = 5;
  localparam int TYPE_W    = 2;
  localparam int SPEED_W   = 4;
  localparam int MS_W      = 16;
  localparam int PROD_W    = SPEED_W + MS_W;  // speed delta times hold time
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_ADDR_W = 2;
  localparam logic [MS_W-1:0] MS_SAT = '1;

  typedef enum logic [1:0] {
    KIND_SCAN = 2'd0,
    KIND_TICK = 2'd1,
    KIND_POLL = 2'd2
  } kind_t;

  typedef enum logic [TYPE_W-1:0] {
    EV_KEY  = 2'd0,
    EV_REL  = 2'd1,
    EV_SYNC = 2'd2
  } ev_type_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_HOLDOFF   = 2'd0,
    REG_RAMP      = 2'd1,
    REG_MIN_SPEED = 2'd2,
    REG_MAX_SPEED = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEYS,
    ST_DIV,
    ST_ARROWS,
    ST_SYNC
  } state_t;

  localparam logic [CODE_W-1:0] AXIS_X = 10'd0;
  localparam logic [CODE_W-1:0] AXIS_Y = 10'd1;

  // current bit position of the key shifter
  typedef struct packed {
    logic              hit;     // changed, mapped, not the power key
    logic              value;   // 1 press, 0 release
    logic [CODE_W-1:0] code;
    logic              at_end;  // last bit position of the sweep
  } key_slot_t;

  function automatic logic [CODE_W-1:0] key_code(input logic [ROW_W-1:0] row,
                                                 input logic layer);
    logic [CODE_W-1:0] c;
    case (row)
      6'd0:  c = 10'd105;
      6'd1:  c = 10'd103;
      6'd2:  c = 10'd108;
      6'd3:  c = 10'd106;
      6'd4:  c = 10'd272;
      6'd5:  c = 10'd273;
      6'd12: c = 10'd42;
      6'd13: c = 10'd58;
      6'd16: c = 10'd15;
      6'd17: c = layer ? 10'd1  : 10'd14;
      6'd18: c = layer ? 10'd59 : 10'd30;
      6'd19: c = layer ? 10'd60 : 10'd48;
      6'd20: c = layer ? 10'd61 : 10'd46;
      6'd21: c = layer ? 10'd62 : 10'd32;
      6'd22: c = layer ? 10'd63 : 10'd18;
      6'd23: c = layer ? 10'd64 : 10'd33;
      6'd24: c = layer ? 10'd65 : 10'd34;
      6'd25: c = layer ? 10'd66 : 10'd35;
      6'd26: c = layer ? 10'd67 : 10'd23;
      6'd27: c = layer ? 10'd68 : 10'd36;
      6'd28: c = layer ? 10'd87 : 10'd37;
      6'd29: c = layer ? 10'd88 : 10'd38;
      6'd30: c = layer ? 10'd8  : 10'd50;
      6'd31: c = layer ? 10'd9  : 10'd49;
      6'd32: c = layer ? 10'd10 : 10'd24;
      6'd33: c = layer ? 10'd26 : 10'd25;
      6'd34: c = layer ? 10'd27 : 10'd16;
      6'd36: c = layer ? 10'd5  : 10'd19;
      6'd37: c = layer ? 10'd6  : 10'd31;
      6'd38: c = layer ? 10'd7  : 10'd20;
      6'd39: c = layer ? 10'd55 : 10'd22;
      6'd40: c = layer ? 10'd98 : 10'd47;
      6'd42: c = layer ? 10'd2  : 10'd17;
      6'd43: c = layer ? 10'd3  : 10'd45;
      6'd44: c = layer ? 10'd4  : 10'd21;
      6'd45: c = layer ? 10'd78 : 10'd44;
      6'd46: c = layer ? 10'd12 : 10'd57;
      6'd48: c = layer ? 10'd11 : 10'd53;
      6'd49: c = layer ? 10'd39 : 10'd52;
      6'd50: c = 10'd29;
      6'd51: c = 10'd56;
      6'd52: c = layer ? 10'd13 : 10'd28;
      default: c = '0;  // unmapped keys
    endcase
    return c;
  endfunction

endpackage

>>> src/kste_key_shifter.sv
// ----------------------------------------------------------------------------
// kste_key_shifter: bit-serial sweep over the changed-key bitmap
// Shifts the changed mask and new scan one bit per advance, looks up the code.
// ----------------------------------------------------------------------------
module kste_key_shifter
  import kste_pkg::*;
#(
  parameter int SCAN_LEN = 53
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [SCAN_W-1:0] keys_in,
  input  logic [SCAN_W-1:0] vals_in,
  input  logic              advance,
  input  logic              layer,
  output key_slot_t         slot
);

  localparam int IDX_W = $clog2(SCAN_LEN);

  logic [SCAN_LEN-1:0] keys_r, keys_nxt;
  logic [SCAN_LEN-1:0] vals_r, vals_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [CODE_W-1:0]   code;

  always_comb begin
    keys_nxt = keys_r;
    vals_nxt = vals_r;
    idx_nxt  = idx_r;
    if (load) begin
      keys_nxt = keys_in[SCAN_LEN-1:0];
      vals_nxt = vals_in[SCAN_LEN-1:0];
      idx_nxt  = '0;
    end else if (advance) begin
      keys_nxt = {1'b0, keys_r[SCAN_LEN-1:1]};
      vals_nxt = {1'b0, vals_r[SCAN_LEN-1:1]};
      idx_nxt  = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    keys_r <= keys_nxt;
    vals_r <= vals_nxt;
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  assign code = key_code(ROW_W'(idx_r), layer);

  // power key never reported; zero code means unmapped
  assign slot.hit    = keys_r[0] && (idx_r != IDX_W'(POWER_BIT)) && (code != '0);
  assign slot.value  = vals_r[0];
  assign slot.code   = code;
  assign slot.at_end = (idx_r == IDX_W'(SCAN_LEN - 1));

endmodule

>>> src/kste_step_divider.sv
// ----------------------------------------------------------------------------
// kste_step_divider: restoring divider, one quotient bit per cycle
// Divides speed delta times hold time by the ramp length.
// ----------------------------------------------------------------------------
module kste_step_divider
  import kste_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [MS_W-1:0]   divisor,
  output logic              done,
  output logic [PROD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(PROD_W + 1);

  logic [PROD_W-1:0] dvd_r, dvd_nxt;
  logic [MS_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [MS_W:0]     trial;
  logic              ge;

  assign trial = {rem_r, dvd_r[PROD_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(PROD_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? MS_W'(trial - {1'b0, divisor}) : trial[MS_W-1:0];
      dvd_nxt  = {dvd_r[PROD_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

>>> src/key_scan_to_event_encoder.sv
// ----------------------------------------------------------------------------
// key_scan_to_event_encoder: key scan bitmap to input event stream
// Key press/release events with layers, pointer mode and sync reports.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per scan bitmap (tuser kind 0), millisecond tick
//           (kind 1) or pointer poll (kind 2); tdata carries the bitmap.
//   out_* : one transaction per event; tuser is the event type, tlast marks
//           the closing sync event of a run.
//   cfg_* : register writes, only while the block is idle.
// Sequencing:
//   A tick, reserved kind, unchanged scan or poll that emits nothing leaves the block idle.
//   A changed scan: accept, a sweep over each key position (KEY_COUNT,
//   capped at the 53 table rows), then a sync step if any key event was sent.
//   A poll: accept, the four arrow positions and sync; a ramping speed first
//   runs the bit-serial step divider.
//   in_tready is high only while idle; an output register holds one event,
//   so a stalled receiver stalls the sweep without losing anything.
// Reset: no events pending, pointer mode off, layer 0, toggle timer saturated,
//   registers at their defaults.
// ----------------------------------------------------------------------------
module key_scan_to_event_encoder
  import kste_pkg::*;
#(
  parameter int KEY_COUNT   = 53,
  parameter int LAYER_COUNT = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [52:0] scan_bits, [55:53] zero
  input  logic [1:0]            in_tuser,   // [1:0] kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [9:0] event_code, [14:10] event_value
  output logic [TYPE_W-1:0]     out_tuser,  // [1:0] event_type
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [MS_W-1:0]       cfg_wdata
);

  localparam int SCAN_LEN = (KEY_COUNT < ROM_ROWS) ? KEY_COUNT : ROM_ROWS;

  // configuration
  logic [MS_W-1:0]    holdoff_r, ramp_r;
  logic [SPEED_W-1:0] min_speed_r, max_speed_r;

  // block state
  state_t             state_r, state_nxt;
  logic [SCAN_W-1:0]  previous_scan_r, previous_scan_nxt;
  logic               pointer_mode_r, pointer_mode_nxt;
  logic               layer_r, layer_nxt;
  logic               pointer_active_r, pointer_active_nxt;
  logic [MS_W-1:0]    since_toggle_r, since_toggle_nxt;
  logic [MS_W-1:0]    held_r, held_nxt;
  logic               any_r, any_nxt;
  logic [ARROW_W-1:0] arw_r, arw_nxt;
  logic [1:0]         arw_idx_r, arw_idx_nxt;
  logic [SPEED_W-1:0] step_r, step_nxt;
  logic               neg_r, neg_nxt;

  // output register
  logic               out_valid_r;
  ev_type_t           out_type_r;
  logic [CODE_W-1:0]  out_code_r;
  logic [VAL_W-1:0]   out_value_r;
  logic               out_last_r;

  // accept decode
  logic               in_accept;
  kind_t              kind;
  logic [SCAN_W-1:0]  scan, changed, keys_load;
  logic               toggle, mode_new, arrows_held;
  logic               scan_go, poll_go, direct;
  logic [MS_W-1:0]    h_eff;
  logic [SPEED_W-1:0] mag;
  logic               neg;
  logic [PROD_W-1:0]  prod;

  // engine
  key_slot_t          slot;
  logic               div_done;
  logic [PROD_W-1:0]  quotient;
  logic               slot_free, emit, key_adv, arw_adv;
  ev_type_t           emit_type;
  logic [CODE_W-1:0]  emit_code;
  logic [VAL_W-1:0]   emit_value;
  logic               emit_last;
  logic [VAL_W-1:0]   pos_step, neg_step;

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign kind      = kind_t'(in_tuser);
  assign scan      = in_tdata[SCAN_W-1:0];
  assign changed   = previous_scan_r ^ scan;

  assign toggle = changed[POWER_BIT] && scan[POWER_BIT] &&
                  ((since_toggle_r == MS_SAT) || (since_toggle_r > holdoff_r));
  assign mode_new  = pointer_mode_r ^ toggle;
  assign keys_load = mode_new ? {changed[SCAN_W-1:ARROW_W], {ARROW_W{1'b0}}} : changed;
  assign arrows_held = (previous_scan_r[ARROW_W-1:0] != '0);

  assign scan_go = in_accept && (kind == KIND_SCAN) && (changed != '0);
  assign poll_go = in_accept && (kind == KIND_POLL) && pointer_mode_r && arrows_held;

  // step = min + (max - min) * held / ramp, truncated toward zero
  assign h_eff  = pointer_active_r ? held_r : '0;
  assign direct = (ramp_r == '0) || (h_eff >= ramp_r);
  assign neg    = max_speed_r < min_speed_r;
  assign mag    = neg ? (min_speed_r - max_speed_r) : (max_speed_r - min_speed_r);
  assign prod   = PROD_W'(mag) * PROD_W'(h_eff);

  kste_key_shifter #(
    .SCAN_LEN (SCAN_LEN)
  ) u_shifter (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (scan_go),
    .keys_in (keys_load),
    .vals_in (scan),
    .advance (key_adv),
    .layer   (layer_r),
    .slot    (slot)
  );

  kste_step_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (poll_go && !direct),
    .dividend (prod),
    .divisor  (ramp_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign slot_free = !out_valid_r || out_tready;
  assign pos_step  = {1'b0, step_r};
  assign neg_step  = VAL_W'(-pos_step);

  // engine outputs
  always_comb begin
    emit       = 1'b0;
    key_adv    = 1'b0;
    arw_adv    = 1'b0;
    emit_type  = EV_SYNC;
    emit_code  = '0;
    emit_value = '0;
    emit_last  = 1'b0;
    case (state_r)
      ST_KEYS: begin
        key_adv    = !slot.hit || slot_free;
        emit       = slot.hit && slot_free;
        emit_type  = EV_KEY;
        emit_code  = slot.code;
        emit_value = VAL_W'(slot.value);
      end
      ST_ARROWS: begin
        arw_adv    = !arw_r[0] || slot_free;
        emit       = arw_r[0] && slot_free;
        emit_type  = EV_REL;
        // left -X, up -Y, down +Y, right +X
        emit_code  = (arw_idx_r == 2'd1 || arw_idx_r == 2'd2) ? AXIS_Y : AXIS_X;
        emit_value = (arw_idx_r == 2'd0 || arw_idx_r == 2'd1) ? neg_step : pos_step;
      end
      ST_SYNC: begin
        emit      = slot_free;
        emit_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (scan_go) begin
          state_nxt = ST_KEYS;
        end else if (poll_go) begin
          state_nxt = direct ? ST_ARROWS : ST_DIV;
        end
      end
      ST_KEYS: begin
        if (key_adv && slot.at_end) begin
          state_nxt = (any_r || emit) ? ST_SYNC : ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_ARROWS;
        end
      end
      ST_ARROWS: begin
        if (arw_adv && arw_idx_r == 2'd3) begin
          state_nxt = ST_SYNC;
        end
      end
      ST_SYNC: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // block state updates
  always_comb begin
    previous_scan_nxt  = previous_scan_r;
    pointer_mode_nxt   = pointer_mode_r;
    layer_nxt          = layer_r;
    pointer_active_nxt = pointer_active_r;
    since_toggle_nxt   = since_toggle_r;
    held_nxt           = held_r;
    any_nxt            = any_r;
    arw_nxt            = arw_r;
    arw_idx_nxt        = arw_idx_r;
    step_nxt           = step_r;
    neg_nxt            = neg_r;

    if (in_accept) begin
      case (kind)
        KIND_SCAN: begin
          if (changed != '0) begin
            pointer_mode_nxt = mode_new;
            if (toggle) begin
              pointer_active_nxt = 1'b0;
              since_toggle_nxt   = '0;
            end
            if (scan[LAYER0_KEY]) begin
              layer_nxt = 1'b0;
            end else if (scan[LAYER1_KEY] && (LAYER_COUNT > 1)) begin
              layer_nxt = 1'b1;
            end
            // arrows all released in pointer mode
            if (mode_new && (changed[ARROW_W-1:0] != '0) && (scan[ARROW_W-1:0] == '0)) begin
              pointer_active_nxt = 1'b0;
            end
            previous_scan_nxt = scan;
            any_nxt           = 1'b0;
          end
        end
        KIND_TICK: begin
          if (since_toggle_r != MS_SAT) begin
            since_toggle_nxt = since_toggle_r + 1'b1;
          end
          if (pointer_active_r && held_r != MS_SAT) begin
            held_nxt = held_r + 1'b1;
          end
        end
        KIND_POLL: begin
          if (pointer_mode_r) begin
            if (!arrows_held) begin
              pointer_active_nxt = 1'b0;
            end else begin
              pointer_active_nxt = 1'b1;
              held_nxt    = h_eff;
              arw_nxt     = previous_scan_r[ARROW_W-1:0];
              arw_idx_nxt = '0;
              step_nxt    = max_speed_r;
              neg_nxt     = neg;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (state_r == ST_KEYS && emit) begin
      any_nxt = 1'b1;
    end
    if (div_done) begin
      step_nxt = neg_r ? (min_speed_r - quotient[SPEED_W-1:0])
                       : (min_speed_r + quotient[SPEED_W-1:0]);
    end
    if (arw_adv) begin
      arw_nxt     = {1'b0, arw_r[ARROW_W-1:1]};
      arw_idx_nxt = arw_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    arw_r  <= arw_nxt;
    step_r <= step_nxt;
    neg_r  <= neg_nxt;
    if (emit) begin
      out_type_r  <= emit_type;
      out_code_r  <= emit_code;
      out_value_r <= emit_value;
      out_last_r  <= emit_last;
    end
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      previous_scan_r  <= '0;
      pointer_mode_r   <= 1'b0;
      layer_r          <= 1'b0;
      pointer_active_r <= 1'b0;
      since_toggle_r   <= MS_SAT;
      held_r           <= '0;
      any_r            <= 1'b0;
      arw_idx_r        <= '0;
      out_valid_r      <= 1'b0;
      holdoff_r        <= 16'd300;
      ramp_r           <= 16'd600;
      min_speed_r      <= 4'd1;
      max_speed_r      <= 4'd4;
    end else begin
      state_r          <= state_nxt;
      previous_scan_r  <= previous_scan_nxt;
      pointer_mode_r   <= pointer_mode_nxt;
      layer_r          <= layer_nxt;
      pointer_active_r <= pointer_active_nxt;
      since_toggle_r   <= since_toggle_nxt;
      held_r           <= held_nxt;
      any_r            <= any_nxt;
      arw_idx_r        <= arw_idx_nxt;
      out_valid_r      <= emit || (out_valid_r && !out_tready);
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_HOLDOFF:   holdoff_r   <= cfg_wdata;
          REG_RAMP:      ramp_r      <= cfg_wdata;
          REG_MIN_SPEED: min_speed_r <= cfg_wdata[SPEED_W-1:0];
          REG_MAX_SPEED: max_speed_r <= cfg_wdata[SPEED_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_value_r, out_code_r};
  assign out_tuser  = out_type_r;
  assign out_tlast  = out_last_r;

  a_last_is_sync: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == EV_SYNC)
    else $error("closing event is not a sync report");

  a_active_needs_mode: assert property (@(posedge clk) disable iff (!rst_n)
    pointer_active_r |-> pointer_mode_r)
    else $error("pointer active outside pointer mode");

  a_toggle_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
    $changed(pointer_mode_r) |-> since_toggle_r == '0)
    else $error("mode toggle without timer restart");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

endmodule

>>> test/key_scan_to_event_encoder_tb.sv
// ----------------------------------------------------------------------------
// key_scan_to_event_encoder_tb: self-checking bench for the key event encoder
// A directed table of scans, ticks and polls, then random sequences under
// several register settings. Every event transaction is checked against
// expected events from an in-bench model or from the directed rows. The
// input side sends in bursts and the output side stalls on its own pattern.
// ----------------------------------------------------------------------------
module key_scan_to_event_encoder_tb
  import kste_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_COUNT     = 53;
  localparam int LAYER_COUNT   = 2;
  localparam int DIR_ROWS      = 23;
  localparam int PHASE_ITEMS   = 45;
  localparam int SETTLE_CYCLES = 100;  // longer than a full sweep or a ramping poll
  localparam int CYCLE_LIMIT   = 2000000;

  localparam logic [1:0]        KIND_RESERVED = 2'd3;
  localparam logic [SCAN_W-1:0] BIT0          = 53'd1;
  localparam logic [SCAN_W-1:0] ALL_KEYS      = {SCAN_W{1'b1}};

  typedef struct packed {
    ev_type_t          etype;
    logic [CODE_W-1:0] code;
    logic [VAL_W-1:0]  value;
    logic              last;
  } key_event_t;

  // one directed row; typed rows carry their own expected events
  typedef struct packed {
    logic [1:0]        kind;
    logic [SCAN_W-1:0] scan;
    logic              typed;
    logic [1:0]        n_typed;
    key_event_t        ev0;
    key_event_t        ev1;
  } stim_row_t;

  localparam key_event_t SYNC_EV = key_event_t'{EV_SYNC, 10'd0, 5'd0, 1'b1};
  localparam key_event_t NO_EV   = '0;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [1:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [TYPE_W-1:0]     out_tuser;
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [MS_W-1:0]       cfg_wdata  = '0;

  key_scan_to_event_encoder #(
    .KEY_COUNT  (KEY_COUNT),
    .LAYER_COUNT(LAYER_COUNT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // key code per layer and key position
  int unsigned keymap [2][53] = '{
    '{105, 103, 108, 106, 272, 273, 0, 0, 0, 0, 0, 0, 42, 58, 0, 0, 15, 14,
      30, 48, 46, 32, 18, 33, 34, 35, 23, 36, 37, 38, 50, 49, 24, 25, 16, 0,
      19, 31, 20, 22, 47, 0, 17, 45, 21, 44, 57, 0, 53, 52, 29, 56, 28},
    '{105, 103, 108, 106, 272, 273, 0, 0, 0, 0, 0, 0, 42, 58, 0, 0, 15, 1,
      59, 60, 61, 62, 63, 64, 65, 66, 67, 68, 87, 88, 8, 9, 10, 26, 27, 0,
      5, 6, 7, 55, 98, 0, 2, 3, 4, 78, 12, 0, 11, 39, 29, 56, 13}
  };

  // encoder model state and registers
  logic [SCAN_W-1:0]  prev_keys;
  logic               ptr_mode;
  logic               layer;
  logic               ptr_active;
  logic [MS_W-1:0]    since_toggle;
  logic [MS_W-1:0]    hold_ms;
  logic [MS_W-1:0]    holdoff_ms;
  logic [MS_W-1:0]    ramp_len;
  logic [SPEED_W-1:0] speed_lo;
  logic [SPEED_W-1:0] speed_hi;

  key_event_t pending_events [$];
  key_event_t head_event;
  bit         model_records = 1'b1;

  int fail_count     = 0;
  int events_checked = 0;
  int scans_sent     = 0;
  int ticks_sent     = 0;
  int polls_sent     = 0;
  int others_sent    = 0;
  int settings_used  = 1;
  int mode_toggles   = 0;
  int burst_left     = 0;
  int cycle_count    = 0;
  int stall_mode     = 0;
  int stall_left     = 0;
  int rx_phase       = 0;

  function automatic void push_event(ev_type_t t, logic [CODE_W-1:0] code,
                                     logic [VAL_W-1:0] value, logic last);
    if (model_records)
      pending_events.push_back(key_event_t'{t, code, value, last});
  endfunction

  // advance the model by one accepted input and queue the events it causes
  function automatic void encode_input(input logic [1:0] kind,
                                       input logic [SCAN_W-1:0] scan);
    logic [SCAN_W-1:0] changed;
    logic [SCAN_W-1:0] keys;
    logic [ARROW_W-1:0] arrows;
    int n;
    int s;
    n = 0;
    case (kind)
      KIND_SCAN: begin
        changed = prev_keys ^ scan;
        if (changed != '0) begin
          if (changed[POWER_BIT] && scan[POWER_BIT]) begin
            if (since_toggle == MS_SAT || since_toggle > holdoff_ms) begin
              ptr_mode     = ~ptr_mode;
              ptr_active   = 1'b0;
              since_toggle = '0;
              mode_toggles++;
            end
          end
          if (scan[LAYER0_KEY])
            layer = 1'b0;
          else if (scan[LAYER1_KEY] && LAYER_COUNT > 1)
            layer = 1'b1;
          keys = ptr_mode ? (changed & ~53'hF) : changed;
          for (int i = 0; i < SCAN_W; i++) begin
            if (i >= KEY_COUNT) break;
            if (keys[i] && i != POWER_BIT && keymap[layer][i] != 0) begin
              push_event(EV_KEY, CODE_W'(keymap[layer][i]), {4'b0, scan[i]}, 1'b0);
              n++;
            end
          end
          if (n > 0) push_event(EV_SYNC, '0, '0, 1'b1);
          // arrows let go while pointing ends the hold
          if (ptr_mode && changed[ARROW_W-1:0] != '0 && scan[ARROW_W-1:0] == '0)
            ptr_active = 1'b0;
          prev_keys = scan;
        end
      end
      KIND_TICK: begin
        if (since_toggle != MS_SAT) since_toggle++;
        if (ptr_active && hold_ms != MS_SAT) hold_ms++;
      end
      KIND_POLL: begin
        if (ptr_mode) begin
          arrows = prev_keys[ARROW_W-1:0];
          if (arrows == '0) begin
            ptr_active = 1'b0;
          end else begin
            if (!ptr_active) begin
              ptr_active = 1'b1;
              hold_ms    = '0;
            end
            if (ramp_len == '0 || hold_ms >= ramp_len)
              s = int'(speed_hi);
            else
              s = int'(speed_lo) + ((int'(speed_hi) - int'(speed_lo)) * int'(hold_ms))
                  / int'(ramp_len);
            if (arrows[0]) push_event(EV_REL, AXIS_X, VAL_W'(-s), 1'b0);
            if (arrows[1]) push_event(EV_REL, AXIS_Y, VAL_W'(-s), 1'b0);
            if (arrows[2]) push_event(EV_REL, AXIS_Y, VAL_W'(s), 1'b0);
            if (arrows[3]) push_event(EV_REL, AXIS_X, VAL_W'(s), 1'b0);
            push_event(EV_SYNC, '0, '0, 1'b1);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] kind, input logic [SCAN_W-1:0] scan);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{(IN_DATA_W - SCAN_W){1'b0}}, scan};
    do @(posedge clk); while (!in_tready);
    encode_input(kind, scan);
    case (kind)
      KIND_SCAN: scans_sent++;
      KIND_TICK: ticks_sent++;
      KIND_POLL: polls_sent++;
      default:   others_sent++;
    endcase
  endtask

  // stop sending, wait for every expected event, then let the block settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [MS_W-1:0] holdoff, input logic [MS_W-1:0] ramp,
                              input logic [SPEED_W-1:0] lo, input logic [SPEED_W-1:0] hi);
    logic [MS_W-1:0] vals [4];
    wait_drained();
    // speed registers keep only their low nibble; the rest is junk on purpose
    vals[0] = holdoff;
    vals[1] = ramp;
    vals[2] = {12'($urandom), lo};
    vals[3] = {12'($urandom), hi};
    for (int r = 0; r < 4; r++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_ADDR_W'(r);
      cfg_wdata <= vals[r];
      @(posedge clk);
      case (cfg_reg_t'(r))
        REG_HOLDOFF:   holdoff_ms = vals[r];
        REG_RAMP:      ramp_len   = vals[r];
        REG_MIN_SPEED: speed_lo   = vals[r][SPEED_W-1:0];
        REG_MAX_SPEED: speed_hi   = vals[r][SPEED_W-1:0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // output stall pattern, picked anew at random from four modes
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(50, 300);
    end
    stall_left--;
    rx_phase++;
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= (rx_phase % 5) != 0;
      default: out_tready <= (rx_phase % 16) < 4;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected event transaction: type %0d code %0d value %0d last %0b",
               out_tuser, out_tdata[9:0], $signed(out_tdata[14:10]), out_tlast);
        fail_count++;
      end else begin
        head_event = pending_events.pop_front();
        events_checked++;
        if (out_tuser !== head_event.etype) begin
          $error("event_type: expected %0d, got %0d", head_event.etype, out_tuser);
          fail_count++;
        end
        if (out_tdata[9:0] !== head_event.code) begin
          $error("event_code: expected %0d, got %0d", head_event.code, out_tdata[9:0]);
          fail_count++;
        end
        if (out_tdata[14:10] !== head_event.value) begin
          $error("event_value: expected %0d, got %0d", $signed(head_event.value),
                 $signed(out_tdata[14:10]));
          fail_count++;
        end
        if (out_tlast !== head_event.last) begin
          $error("last: expected %0b, got %0b", head_event.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t         dir_tbl [DIR_ROWS];
    stim_row_t         row;
    logic [SCAN_W-1:0] next_scan;
    logic [1:0]        next_kind;
    int                pick;
    int                idx;
    int                counted;

    // model at reset
    prev_keys    = '0;
    ptr_mode     = 1'b0;
    layer        = 1'b0;
    ptr_active   = 1'b0;
    since_toggle = MS_SAT;
    hold_ms      = '0;
    holdoff_ms   = 16'd300;
    ramp_len     = 16'd600;
    speed_lo     = 4'd1;
    speed_hi     = 4'd4;

    dir_tbl[0]  = '{KIND_SCAN, BIT0 << 16, 1'b1, 2'd2,
                    key_event_t'{EV_KEY, 10'd15, 5'd1, 1'b0}, SYNC_EV};
    dir_tbl[1]  = '{KIND_SCAN, '0, 1'b1, 2'd2,
                    key_event_t'{EV_KEY, 10'd15, 5'd0, 1'b0}, SYNC_EV};
    dir_tbl[2]  = '{KIND_SCAN, '0, 1'b1, 2'd0, NO_EV, NO_EV};          // unchanged
    dir_tbl[3]  = '{KIND_SCAN, BIT0 << 6, 1'b1, 2'd0, NO_EV, NO_EV};   // unmapped key
    dir_tbl[4]  = '{KIND_SCAN, (BIT0 << 52) | (BIT0 << 6), 1'b1, 2'd2,
                    key_event_t'{EV_KEY, 10'd28, 5'd1, 1'b0}, SYNC_EV};
    dir_tbl[5]  = '{KIND_SCAN, '0, 1'b1, 2'd2,
                    key_event_t'{EV_KEY, 10'd28, 5'd0, 1'b0}, SYNC_EV};
    dir_tbl[6]  = '{KIND_RESERVED, ALL_KEYS, 1'b1, 2'd0, NO_EV, NO_EV};
    dir_tbl[7]  = '{KIND_POLL, '0, 1'b1, 2'd0, NO_EV, NO_EV};          // not pointing
    dir_tbl[8]  = '{KIND_SCAN, ALL_KEYS, 1'b0, 2'd0, NO_EV, NO_EV};    // toggles pointing
    dir_tbl[9]  = '{KIND_SCAN, ALL_KEYS, 1'b1, 2'd0, NO_EV, NO_EV};
    dir_tbl[10] = '{KIND_TICK, '0, 1'b1, 2'd0, NO_EV, NO_EV};
    dir_tbl[11] = '{KIND_POLL, '0, 1'b0, 2'd0, NO_EV, NO_EV};
    dir_tbl[12] = '{KIND_TICK, ALL_KEYS, 1'b1, 2'd0, NO_EV, NO_EV};
    dir_tbl[13] = '{KIND_TICK, '0, 1'b1, 2'd0, NO_EV, NO_EV};
    dir_tbl[14] = '{KIND_TICK, '0, 1'b1, 2'd0, NO_EV, NO_EV};
    dir_tbl[15] = '{KIND_POLL, '0, 1'b0, 2'd0, NO_EV, NO_EV};
    dir_tbl[16] = '{KIND_SCAN, BIT0, 1'b0, 2'd0, NO_EV, NO_EV};
    dir_tbl[17] = '{KIND_POLL, '0, 1'b0, 2'd0, NO_EV, NO_EV};
    dir_tbl[18] = '{KIND_SCAN, BIT0 << POWER_BIT, 1'b0, 2'd0, NO_EV, NO_EV};  // in holdoff
    dir_tbl[19] = '{KIND_POLL, '0, 1'b0, 2'd0, NO_EV, NO_EV};                 // no arrows
    dir_tbl[20] = '{KIND_SCAN, (BIT0 << 15) | (BIT0 << 18), 1'b0, 2'd0, NO_EV, NO_EV};
    dir_tbl[21] = '{KIND_SCAN, (BIT0 << 14) | (BIT0 << 17) | (BIT0 << 18), 1'b0, 2'd0,
                    NO_EV, NO_EV};
    dir_tbl[22] = '{KIND_SCAN, '0, 1'b0, 2'd0, NO_EV, NO_EV};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      row = dir_tbl[r];
      model_records = !row.typed;
      send_item(row.kind, row.scan);
      model_records = 1'b1;
      if (row.typed && row.n_typed > 0) pending_events.push_back(row.ev0);
      if (row.typed && row.n_typed > 1) pending_events.push_back(row.ev1);
    end

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       program_regs(16'd0, 16'd1, 4'd0, 4'd15);
        1:       program_regs(16'd5, 16'd0, 4'd7, 4'd3);          // ramp off
        2:       program_regs(16'hFFFF, 16'hFFFF, 4'd15, 4'd0);   // downward ramp
        3:       program_regs(16'd2, 16'd20, 4'd3, 4'd12);
        4:       program_regs(16'($urandom), 16'($urandom_range(1, 40)),
                              4'($urandom), 4'($urandom));
        default: program_regs(16'd1, 16'd10, 4'd15, 4'd15);
      endcase
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        next_scan = '0;
        if (pick < 35) begin
          next_kind = KIND_SCAN;
          next_scan = prev_keys;
          case ($urandom_range(0, 9))
            0: next_scan = SCAN_W'({$urandom, $urandom});
            1: next_scan = '0;
            2: next_scan = ALL_KEYS;
            3, 4: next_scan[POWER_BIT] = ~next_scan[POWER_BIT];
            5, 6: next_scan[3:0] = next_scan[3:0] ^ 4'($urandom_range(1, 15));
            7: begin
              next_scan[LAYER0_KEY] = 1'($urandom);
              next_scan[LAYER1_KEY] = 1'($urandom);
              idx = $urandom_range(16, SCAN_W - 1);
              next_scan[idx] = ~next_scan[idx];
            end
            default: begin
              repeat ($urandom_range(1, 3)) begin
                idx = $urandom_range(0, SCAN_W - 1);
                next_scan[idx] = ~next_scan[idx];
              end
            end
          endcase
        end else if (pick < 70) begin
          next_kind = KIND_TICK;
        end else if (pick < 94) begin
          next_kind = KIND_POLL;
        end else begin
          next_kind = KIND_RESERVED;
          next_scan = SCAN_W'({$urandom, $urandom});
        end
        // reserved kinds and polls outside pointing do nothing
        if (next_kind != KIND_RESERVED && !(next_kind == KIND_POLL && !ptr_mode))
          counted++;
        send_item(next_kind, next_scan);
        if ($urandom_range(0, 39) == 0) wait_drained();
      end
    end

    wait_drained();
    $display("Run covered %0d scans, %0d ticks, %0d polls and %0d reserved transactions",
             scans_sent, ticks_sent, polls_sent, others_sent);
    $display("across %0d register settings: %0d events compared, %0d pointer toggles",
             settings_used, events_checked, mode_toggles);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
